// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared codes and types for the sorted priority queue
// Action and status codes, and the per-cycle operation word broadcast to
// every slot of the sorted chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Action codes carried on the input tuser
  localparam logic [1:0] ACT_INSERT     = 2'd0;
  localparam logic [1:0] ACT_REMOVE_TOP = 2'd1;
  localparam logic [1:0] ACT_REMOVE_PRI = 2'd2;

  // Status codes carried on the output tuser
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  // Operation broadcast to all slots in the execute cycle
  typedef struct packed {
    logic ins_en;   // place the new entry, shift lower entries back
    logic rmf_en;   // every slot takes its right neighbor
    logic rmp_en;   // slots at or after the match take their right neighbor
  } spq_op_t;

endpackage : spq_pkg

// ===== sv/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue: priority queue kept sorted in a chain of slots
// Entries sit in descending priority order, slot 0 at the front. Each word
// inserts, removes the front or removes the first entry of a given priority,
// and returns status, count and the front entry.
//
//   port group   dir  tdata (low bit up)                           tuser
//   s_axis       in   item_value, item_priority                    action
//   m_axis       out  queue_empty, entry_count, front_value,       status
//                     front_priority
//
// Each word is captured in the idle state, then executed in the execute state,
// in which every slot compares with the broadcast priority and shifts in parallel.
// The execute cycle waits while the output register holds an untaken word;
// a new word is taken while a result still waits.
// Reset empties the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY       = 16,
  parameter int VALUE_WIDTH    = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // item_value, item_priority
  input  logic [((VALUE_WIDTH+PRIORITY_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // action
  input  logic [1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // queue_empty, entry_count, front_value, front_priority
  output logic [((1+$clog2(CAPACITY+1)+VALUE_WIDTH+PRIORITY_WIDTH+7)/8)*8-1:0]
               m_axis_tdata,
  // status
  output logic [1:0] m_axis_tuser
);
  import spq_pkg::*;

  localparam int VW  = VALUE_WIDTH;
  localparam int PW  = PRIORITY_WIDTH;
  localparam int CW  = $clog2(CAPACITY+1);
  localparam int ODW = ((1+CW+VW+PW+7)/8)*8;
  localparam int OPW = ODW - (1+CW+VW+PW);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e        state_q, state_d;
  logic [1:0]    act_q;
  logic [VW-1:0] cval_q;
  logic [PW-1:0] cpri_q;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q;
  logic [ODW-1:0] out_data_q;
  logic [1:0]    out_stat_q;

  logic          in_fire, out_free, go;
  logic          full, empty, found;
  logic [1:0]    stat;
  spq_op_t       op;

  logic          c_valid [CAPACITY];
  logic [VW-1:0] c_val   [CAPACITY];
  logic [PW-1:0] c_pri   [CAPACITY];
  logic          c_ge    [CAPACITY];
  logic [CAPACITY-1:0] c_eq;
  logic          n_valid [CAPACITY];
  logic [VW-1:0] n_val   [CAPACITY];
  logic [PW-1:0] n_pri   [CAPACITY];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign go            = (state_q == ST_EXEC) && out_free;

  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);
  assign found = |c_eq;

  // Decide the operation and its status
  always_comb begin
    op      = '0;
    stat    = STAT_OK;
    count_d = count_q;
    case (act_q)
      ACT_INSERT: begin
        if (full) begin
          stat = STAT_FULL;
        end else begin
          op.ins_en = go;
          count_d   = count_q + 1'b1;
        end
      end
      ACT_REMOVE_TOP: begin
        if (empty) begin
          stat = STAT_EMPTY;
        end else begin
          op.rmf_en = go;
          count_d   = count_q - 1'b1;
        end
      end
      ACT_REMOVE_PRI: begin
        if (empty) begin
          stat = STAT_EMPTY;
        end else if (!found) begin
          stat = STAT_NOT_FOUND;
        end else begin
          op.rmp_en = go;
          count_d   = count_q - 1'b1;
        end
      end
      default: begin
        stat = STAT_OK;
      end
    endcase
  end

  // Chain of slots
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    logic          lv, lg, rv;
    logic [VW-1:0] lval, rval;
    logic [PW-1:0] lpri, rpri;

    if (i == 0) begin : g_head
      assign lv   = 1'b0;
      assign lval = '0;
      assign lpri = '0;
      assign lg   = 1'b0;
    end else begin : g_mid
      assign lv   = c_valid[i-1];
      assign lval = c_val[i-1];
      assign lpri = c_pri[i-1];
      assign lg   = c_ge[i-1];
    end

    if (i == CAPACITY-1) begin : g_tail
      assign rv   = 1'b0;
      assign rval = '0;
      assign rpri = '0;
    end else begin : g_body
      assign rv   = c_valid[i+1];
      assign rval = c_val[i+1];
      assign rpri = c_pri[i+1];
    end

    spq_slot #(
      .VW(VW),
      .PW(PW)
    ) u_slot (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .cmd_val_i    (cval_q),
      .cmd_pri_i    (cpri_q),
      .left_valid_i (lv),
      .left_val_i   (lval),
      .left_pri_i   (lpri),
      .left_ge_i    (lg),
      .right_valid_i(rv),
      .right_val_i  (rval),
      .right_pri_i  (rpri),
      .valid_o      (c_valid[i]),
      .val_o        (c_val[i]),
      .pri_o        (c_pri[i]),
      .ge_o         (c_ge[i]),
      .eq_o         (c_eq[i]),
      .valid_d_o    (n_valid[i]),
      .val_d_o      (n_val[i]),
      .pri_d_o      (n_pri[i])
    );
  end

  // Sequence capture and execute
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (go) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the word; mask fields to their widths
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q  <= s_axis_tuser;
      cval_q <= s_axis_tdata[VW-1:0];
      cpri_q <= s_axis_tdata[VW+PW-1:VW];
    end
  end

  // Load the result word from the front slot's next content
  always_ff @(posedge clk_i) begin
    if (go) begin
      out_stat_q <= stat;
      if (!n_valid[0]) begin
        out_data_q <= {{OPW{1'b0}}, {PW{1'b0}}, {VW{1'b0}}, count_d, 1'b1};
      end else begin
        out_data_q <= {{OPW{1'b0}}, n_pri[0], n_val[0], count_d, 1'b0};
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

endmodule : sorted_priority_queue

// ===== sv/spq_slot.sv =====
// ----------------------------------------------------------------------------
// spq_slot: one position of the sorted chain
// Holds one entry, compares it with the broadcast priority and takes the
// new entry, its left neighbor or its right neighbor as the operation asks.
// ----------------------------------------------------------------------------
module spq_slot #(
  parameter int VW = 32,
  parameter int PW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spq_pkg::spq_op_t op_i,
  input  logic [VW-1:0]   cmd_val_i,
  input  logic [PW-1:0]   cmd_pri_i,
  input  logic            left_valid_i,
  input  logic [VW-1:0]   left_val_i,
  input  logic [PW-1:0]   left_pri_i,
  input  logic            left_ge_i,
  input  logic            right_valid_i,
  input  logic [VW-1:0]   right_val_i,
  input  logic [PW-1:0]   right_pri_i,
  output logic            valid_o,
  output logic [VW-1:0]   val_o,
  output logic [PW-1:0]   pri_o,
  output logic            ge_o,
  output logic            eq_o,
  output logic            valid_d_o,
  output logic [VW-1:0]   val_d_o,
  output logic [PW-1:0]   pri_d_o
);
  import spq_pkg::*;

  logic          valid_q, valid_d;
  logic [VW-1:0] val_q, val_d;
  logic [PW-1:0] pri_q, pri_d;
  logic          ge;

  // Empty slots and entries not above the broadcast priority sit behind it
  assign ge   = !valid_q || (cmd_pri_i >= pri_q);
  assign ge_o = ge;
  assign eq_o = valid_q && (pri_q == cmd_pri_i);

  // Pick the next content of this slot
  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    pri_d   = pri_q;
    if (op_i.ins_en && ge) begin
      if (left_ge_i) begin
        valid_d = left_valid_i;
        val_d   = left_val_i;
        pri_d   = left_pri_i;
      end else begin
        valid_d = 1'b1;
        val_d   = cmd_val_i;
        pri_d   = cmd_pri_i;
      end
    end
    if (op_i.rmf_en || (op_i.rmp_en && ge)) begin
      valid_d = right_valid_i;
      val_d   = right_val_i;
      pri_d   = right_pri_i;
    end
  end

  // Occupied flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    pri_q <= pri_d;
  end

  assign valid_o   = valid_q;
  assign val_o     = val_q;
  assign pri_o     = pri_q;
  assign valid_d_o = valid_d;
  assign val_d_o   = val_d;
  assign pri_d_o   = pri_d;

endmodule : spq_slot

// ===== dv/sorted_priority_queue_checker.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_checker: scoreboard for the sorted priority queue
// Mirrors the sorted entry list from every accepted input word, queues the
// expected status, count and front entry, and compares each output word
// field by field in order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_checker #(
  parameter int CAPACITY       = 16,
  parameter int VALUE_WIDTH    = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  // item_value, item_priority
  input  logic [((VALUE_WIDTH+PRIORITY_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // action
  input  logic [1:0] s_axis_tuser,
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  // queue_empty, entry_count, front_value, front_priority
  input  logic [((1+$clog2(CAPACITY+1)+VALUE_WIDTH+PRIORITY_WIDTH+7)/8)*8-1:0]
               m_axis_tdata,
  // status
  input  logic [1:0] m_axis_tuser,
  output int   err_count_o,
  output int   pending_o
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = VALUE_WIDTH;
  localparam int PW = PRIORITY_WIDTH;

  typedef struct packed {
    logic [1:0]    status;
    logic          queue_empty;
    logic [CW-1:0] count;
    logic [VW-1:0] value;
    logic [PW-1:0] prio;
  } queue_report_t;

  // Mirror of the queue contents, slot 0 at the front
  logic [VW-1:0] slot_value [CAPACITY];
  logic [PW-1:0] slot_prio  [CAPACITY];
  int            held = 0;

  queue_report_t front_reports[$];
  int            fails   = 0;
  int            waiting = 0;

  assign err_count_o = fails;
  assign pending_o   = waiting;

  // Close the gap left by the entry at pos
  task automatic drop_entry(input int pos);
    for (int i = pos; i + 1 < held; i++) begin
      slot_value[i] = slot_value[i+1];
      slot_prio[i]  = slot_prio[i+1];
    end
    held--;
  endtask

  // Apply one action to the mirror and queue the report it must produce
  task automatic apply_action(input logic [1:0] act, input logic [VW-1:0] val,
                              input logic [PW-1:0] pri);
    int            pos;
    queue_report_t rep;
    rep.status = STAT_OK;
    pos = 0;
    case (act)
      ACT_INSERT: begin
        if (held == CAPACITY) begin
          rep.status = STAT_FULL;
        end else begin
          // newest goes ahead of every entry that is not higher
          while (pos < held && pri < slot_prio[pos]) pos++;
          for (int i = held; i > pos; i--) begin
            slot_value[i] = slot_value[i-1];
            slot_prio[i]  = slot_prio[i-1];
          end
          slot_value[pos] = val;
          slot_prio[pos]  = pri;
          held++;
        end
      end
      ACT_REMOVE_TOP: begin
        if (held == 0) rep.status = STAT_EMPTY;
        else drop_entry(0);
      end
      ACT_REMOVE_PRI: begin
        if (held == 0) begin
          rep.status = STAT_EMPTY;
        end else begin
          while (pos < held && slot_prio[pos] != pri) pos++;
          if (pos == held) rep.status = STAT_NOT_FOUND;
          else drop_entry(pos);
        end
      end
      default: ;
    endcase
    rep.queue_empty = (held == 0);
    rep.count       = CW'(held);
    rep.value       = (held == 0) ? '0 : slot_value[0];
    rep.prio        = (held == 0) ? '0 : slot_prio[0];
    front_reports.push_back(rep);
  endtask

  // Compare results first, then predict from the word taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    queue_report_t got;
    queue_report_t want;
    if (!rst_ni) begin
      held = 0;
      front_reports.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status      = m_axis_tuser;
        got.queue_empty = m_axis_tdata[0];
        got.count       = m_axis_tdata[CW:1];
        got.value       = m_axis_tdata[CW+VW:CW+1];
        got.prio        = m_axis_tdata[CW+VW+PW:CW+VW+1];
        if (front_reports.size() == 0) begin
          $error("result word with no prediction waiting");
          fails++;
        end else begin
          want = front_reports.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
          end
          if (got.queue_empty !== want.queue_empty) begin
            $error("queue_empty: expected %0d, got %0d", want.queue_empty,
                   got.queue_empty);
            fails++;
          end
          if (got.count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, got.count);
            fails++;
          end
          if (got.value !== want.value) begin
            $error("front_value: expected %0h, got %0h", want.value, got.value);
            fails++;
          end
          if (got.prio !== want.prio) begin
            $error("front_priority: expected %0h, got %0h", want.prio, got.prio);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_action(s_axis_tuser, s_axis_tdata[VW-1:0], s_axis_tdata[VW+PW-1:VW]);
      end
    end
    waiting = front_reports.size();
  end

endmodule : sorted_priority_queue_checker

// ===== dv/tb_sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue: stream testbench for the sorted priority queue
// Runs a directed pass over empty, full, duplicate-priority and lookup cases,
// then phases of random words that alternately fill and drain the queue,
// with random gaps on both sides, a long receiver stall and a full drain.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int CAPACITY       = 16;
  localparam int VALUE_WIDTH    = 32;
  localparam int PRIORITY_WIDTH = 16;
  localparam int IN_W  = ((VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8;
  localparam int OUT_W = ((1 + $clog2(CAPACITY + 1) + VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8;

  // Action code the block leaves unused
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  localparam int SEGMENTS        = 17;
  localparam int SEGMENT_WORDS   = 100;
  localparam int RX_STALL_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int SETTLE_CYCLES   = 10;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic [1:0]       s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0]       m_axis_tuser;

  int errors;
  int pending;
  int idle_cycles = 0;

  // Stimulus mode flags: quiet turns off idling on both sides
  bit quiet      = 1'b0;
  bit stall_req  = 1'b0;
  bit stall_done = 1'b0;

  sorted_priority_queue #(
    .CAPACITY      (CAPACITY),
    .VALUE_WIDTH   (VALUE_WIDTH),
    .PRIORITY_WIDTH(PRIORITY_WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  sorted_priority_queue_checker #(
    .CAPACITY      (CAPACITY),
    .VALUE_WIDTH   (VALUE_WIDTH),
    .PRIORITY_WIDTH(PRIORITY_WIDTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .err_count_o  (errors),
    .pending_o    (pending)
  );

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one word at a falling edge, hold it until taken; returns at a falling edge
  task automatic send_word(input logic [1:0] act, input logic [VALUE_WIDTH-1:0] val,
                           input logic [PRIORITY_WIDTH-1:0] pri);
    if (!quiet) begin
      while ($urandom_range(99) < 30) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {pri, val};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  // Receiver: random backpressure, one long stall on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_req && !stall_done) begin
        m_axis_tready <= 1'b0;
        repeat (RX_STALL_CYCLES) @(negedge clk_i);
        stall_done = 1'b1;
      end
      m_axis_tready <= quiet || ($urandom_range(99) >= 30);
    end
  end

  // Sender: reset, directed words, random phases, verdict
  initial begin
    logic [1:0]                act;
    logic [PRIORITY_WIDTH-1:0] pri;
    int                        ins_pct;
    int                        roll;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_INSERT;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Removals and the unused code on an empty queue
    send_word(ACT_REMOVE_TOP, $urandom, 16'h0000);
    send_word(ACT_REMOVE_PRI, $urandom, 16'h0000);
    send_word(ACT_RESERVED, $urandom, $urandom);
    // Fill with both extremes and repeated priorities, then insert when full
    send_word(ACT_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(ACT_INSERT, 32'h0000_0000, 16'h0000);
    for (int i = 2; i < CAPACITY; i++) begin
      send_word(ACT_INSERT, $urandom, PRIORITY_WIDTH'((i * 7) % 5));
    end
    send_word(ACT_INSERT, 32'h1234_5678, 16'h8000);
    // Lookup removal at the front, the back, a miss and the middle
    send_word(ACT_REMOVE_PRI, $urandom, 16'hFFFF);
    send_word(ACT_REMOVE_PRI, $urandom, 16'h0000);
    send_word(ACT_REMOVE_PRI, $urandom, 16'h1234);
    send_word(ACT_REMOVE_PRI, $urandom, 16'h0002);
    send_word(ACT_REMOVE_TOP, $urandom, $urandom);
    send_word(ACT_RESERVED, $urandom, $urandom);

    // Random phases: even ones fill the queue, odd ones drain it
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      ins_pct   = (seg % 2 == 0) ? 65 : 25;
      stall_req = (seg == 3);
      quiet     = (seg >= 5 && seg <= 7);
      for (int n = 0; n < SEGMENT_WORDS; n++) begin
        roll = $urandom_range(99);
        if (roll < 3) act = ACT_RESERVED;
        else if (roll < 3 + ins_pct) act = ACT_INSERT;
        else if (roll % 2 == 0) act = ACT_REMOVE_TOP;
        else act = ACT_REMOVE_PRI;
        // Mostly a small pool so removals by priority find matches
        roll = $urandom_range(99);
        if (roll < 60) pri = PRIORITY_WIDTH'($urandom_range(7));
        else if (roll < 75) pri = 16'hFFFF - PRIORITY_WIDTH'($urandom_range(7));
        else pri = PRIORITY_WIDTH'($urandom_range(16'hFFFF));
        send_word(act, $urandom, pri);
      end
      if (seg == 9) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule : tb_sorted_priority_queue
